FILE: src/cfip_pkg.sv
// Package for the cached integer power block: constants, shared types, helpers.
// No dependencies.
package cfip_pkg;
    localparam int EXP_WIDTH_DEF = 32;
    localparam logic [63:0] ONE_BITS = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] ZERO_BITS = 64'h0;

    typedef struct packed {
        logic start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    function automatic logic is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic logic gt_one(input logic [63:0] x);
        return !x[63] && !is_nan(x) && (x[62:0] > ONE_BITS[62:0]);
    endfunction

    function automatic logic feq(input logic [63:0] x, input logic [63:0] y);
        return !is_nan(x) && !is_nan(y) &&
            ((x == y) || (is_zero(x) && is_zero(y)));
    endfunction
endpackage

FILE: src/cfip_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface cfip_if #(parameter int W = 64) (input logic i_clk);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/cfip_ram.sv
// Generic single-port write, single read RAM with registered read data.
// No dependencies.
module cfip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/cfip_fmul.sv
// Multicycle double multiplier, round to nearest even, IEEE special cases.
// Uses cfip_pkg. Mantissa product formed from 27x27 partial products.
module cfip_fmul import cfip_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_mul_req i_req,
    output logic o_done,
    output logic [63:0] o_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_PP = 5'b00010, S_SUM = 5'b00100,
        S_RND = 5'b01000, S_OUT = 5'b10000
    } t_st;
    t_st r_st;
    logic [63:0] r_a, r_b;
    logic r_sign, r_spec;
    logic [63:0] r_spec_val;
    logic signed [13:0] r_exp;
    logic [52:0] r_ma, r_mb;
    logic [1:0] r_k;
    logic [105:0] r_prod;
    logic [63:0] r_res;

    logic [10:0] ea, eb;
    logic [52:0] ma, mb;
    logic signed [13:0] lza, lzb;
    always_comb begin
        ea = r_a[62:52];
        eb = r_b[62:52];
        ma = {(ea != 0), r_a[51:0]};
        mb = {(eb != 0), r_b[51:0]};
        lza = 14'(ea == 11'd0);
        lzb = 14'(eb == 11'd0);
    end

    // Partial products: two 27-bit halves of A times full-ish B split in two.
    logic [26:0] pa, pb;
    logic [53:0] pp;
    always_comb begin
        pa = r_k[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        pb = r_k[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        pp = pa * pb;
    end
    logic [6:0] sh;
    always_comb begin
        unique case (r_k)
            2'd0: sh = 7'd0;
            2'd1, 2'd2: sh = 7'd27;
            default: sh = 7'd54;
        endcase
    end

    // Normalize/round on product.
    logic [6:0] lz;
    logic signed [13:0] e1;
    logic [105:0] nrm;
    logic [7:0] rsh;
    logic [105:0] sh2;
    logic sticky;
    logic [52:0] mant;
    logic g, rb, st;
    logic [53:0] mr;
    logic signed [13:0] ef;
    always_comb begin
        lz = 7'd0;
        for (int i = 105; i >= 0; i--) begin
            if (r_prod[i] && lz == 0 && !(|(r_prod >> (i + 1)))) begin
                lz = 7'(105 - i);
            end
        end
        e1 = r_exp - 14'(lz) + 14'sd1;
        nrm = r_prod << lz;
        rsh = 8'd0;
        if (e1 < 14'sd1) begin
            rsh = (e1 < -14'sd60) ? 8'd60 : 8'(14'sd1 - e1);
        end
        sh2 = nrm >> rsh;
        sticky = |(nrm & ~(~106'd0 << rsh));
        mant = sh2[105:53];
        g = sh2[52];
        rb = (|sh2[51:0]) | sticky;
        st = g && (rb || mant[0]);
        mr = {1'b0, mant} + 54'(st);
        ef = (rsh != 0) ? 14'sd0 : e1;
        if (mr[53]) begin
            mr = mr >> 1;
            ef = ef + 14'sd1;
        end else if (rsh != 0 && mr[52]) begin
            ef = 14'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_req.start) r_st <= S_SUM;
                S_SUM: r_st <= S_PP;
                S_PP: if (r_k == 2'd3) r_st <= S_RND;
                S_RND: r_st <= S_OUT;
                S_OUT: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_a <= i_req.a;
                r_b <= i_req.b;
            end
            S_SUM: begin
                r_sign <= r_a[63] ^ r_b[63];
                r_ma <= ma;
                r_mb <= mb;
                r_exp <= $signed({3'b0, ea}) + lza + $signed({3'b0, eb}) + lzb - 14'sd1023;
                r_k <= 2'd0;
                r_prod <= '0;
                r_spec <= 1'b1;
                if (is_nan(r_a)) r_spec_val <= r_a | 64'h0008_0000_0000_0000;
                else if (is_nan(r_b)) r_spec_val <= r_b | 64'h0008_0000_0000_0000;
                else if ((ea == 11'h7FF && is_zero(r_b)) || (eb == 11'h7FF && is_zero(r_a)))
                    r_spec_val <= 64'h7FF8_0000_0000_0000;
                else if (ea == 11'h7FF || eb == 11'h7FF)
                    r_spec_val <= {r_a[63] ^ r_b[63], 11'h7FF, 52'd0};
                else if (is_zero(r_a) || is_zero(r_b))
                    r_spec_val <= {r_a[63] ^ r_b[63], 63'd0};
                else r_spec <= 1'b0;
            end
            S_PP: begin
                r_prod <= r_prod + (106'(pp) << sh);
                r_k <= r_k + 2'd1;
            end
            S_RND: begin
                if (r_spec) r_res <= r_spec_val;
                else if (ef >= 14'sd2047) r_res <= {r_sign, 11'h7FF, 52'd0};
                else if (ef == 14'sd0 || (rsh != 0 && !mr[52]))
                    r_res <= {r_sign, 11'd0, mr[51:0]};
                else r_res <= {r_sign, ef[10:0], mr[51:0]};
            end
            default: ;
        endcase
    end
    assign o_done = (r_st == S_OUT);
    assign o_res = r_res;
endmodule

FILE: src/cached_float_integer_power.sv
// Top level of the cached integer power block: sequencer, cache, one multiplier.
// Uses cfip_pkg, cfip_if, cfip_ram and cfip_fmul.
// channel | dir | payload
// in      | in  | base_bits[63:0], exponent[31:0] ({exponent, base_bits})
// out     | out | result_bits[63:0]
// Shortcut items pass from the accepting cycle straight to holding the result until it is taken.
// Cached items run each squaring and each product through a sequencer step, a RAM
// read and the multiplier, plus a scan step per clear exponent bit scanned.
// Reset clears the cache to empty. Ready stays low while an item is in work
// and while a result waits to be taken.
module cached_float_integer_power import cfip_pkg::*; #(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    cfip_if.sink i_in,
    cfip_if.source o_out
);
    localparam int AW = $clog2(EXP_WIDTH);
    localparam int CW = $clog2(EXP_WIDTH + 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001, ST_GROW = 8'b00000010, ST_SQ = 8'b00000100,
        ST_TOP = 8'b00001000, ST_SCAN = 8'b00010000, ST_MUL = 8'b00100000,
        ST_RD = 8'b01000000, ST_OUT = 8'b10000000
    } t_st;
    t_st r_st;
    logic [63:0] r_cbase, r_acc, r_res;
    logic [CW-1:0] r_cnt;
    logic [EXP_WIDTH-1:0] r_pow;
    logic [AW-1:0] r_idx, r_top;
    logic r_sq, r_rd_wait;
    logic r_mstart;

    logic [63:0] in_base;
    logic [EXP_WIDTH-1:0] in_pow;
    assign in_base = i_in.data[63:0];
    assign in_pow = i_in.data[64 +: EXP_WIDTH];

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wdata, rdata;
    cfip_ram #(.WIDTH(64), .DEPTH(EXP_WIDTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    t_mul_req mreq;
    logic mdone;
    logic [63:0] mres;
    assign mreq.start = r_mstart;
    assign mreq.a = r_sq ? rdata : r_acc;
    assign mreq.b = rdata;
    cfip_fmul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq),
        .o_done(mdone), .o_res(mres));

    logic [EXP_WIDTH:0] next_pow;
    assign next_pow = (EXP_WIDTH+1)'(1) << r_cnt;
    assign raddr = r_idx;

    assign i_in.ready = (r_st == ST_IDLE);
    assign o_out.valid = (r_st == ST_OUT);
    assign o_out.data = r_res;

    always_comb begin
        we = 1'b0;
        waddr = r_cnt[AW-1:0];
        wdata = mres;
        if (r_st == ST_IDLE && i_in.valid) begin
            waddr = '0;
            wdata = in_base;
            we = !((in_pow <= 1) || (!gt_one(in_base) && (is_zero(in_base) ||
                in_base == ONE_BITS))) &&
                (r_cnt == 0 || !feq(in_base, r_cbase));
        end else if (r_st == ST_SQ && mdone) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_cnt <= '0;
            r_cbase <= ZERO_BITS;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_in.valid) begin
                    r_pow <= in_pow;
                    r_acc <= ONE_BITS;
                    if (!((in_pow > 1) && gt_one(in_base)) && in_pow == 0) begin
                        r_res <= ONE_BITS; r_st <= ST_OUT;
                    end else if (!((in_pow > 1) && gt_one(in_base)) && in_pow == 1) begin
                        r_res <= in_base; r_st <= ST_OUT;
                    end else if (!gt_one(in_base) && is_zero(in_base)) begin
                        r_res <= ZERO_BITS; r_st <= ST_OUT;
                    end else if (!gt_one(in_base) && in_base == ONE_BITS) begin
                        r_res <= ONE_BITS; r_st <= ST_OUT;
                    end else begin
                        if (we) begin
                            r_cbase <= in_base;
                            r_cnt <= CW'(1);
                        end
                        r_st <= ST_GROW;
                    end
                end
                ST_GROW: begin
                    if (r_cnt < CW'(EXP_WIDTH) && next_pow <= (EXP_WIDTH+1)'(r_pow)) begin
                        r_idx <= AW'(r_cnt - CW'(1));
                        r_sq <= 1'b1;
                        r_rd_wait <= 1'b1;
                        r_st <= ST_SQ;
                    end else begin
                        r_top <= AW'(r_cnt - CW'(1));
                        r_idx <= AW'(r_cnt - CW'(1));
                        r_st <= ST_TOP;
                    end
                end
                ST_SQ: begin
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                        r_mstart <= 1'b1;
                    end else if (mdone) begin
                        r_cnt <= r_cnt + CW'(1);
                        r_st <= ST_GROW;
                    end
                end
                ST_TOP: begin
                    r_sq <= 1'b0;
                    if (r_pow[r_top]) begin
                        r_pow[r_top] <= 1'b0;
                        r_rd_wait <= 1'b1;
                        r_st <= ST_MUL;
                    end else begin
                        r_idx <= '0;
                        r_st <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_pow == '0 || r_idx >= r_top) begin
                        r_res <= r_acc; r_st <= ST_OUT;
                    end else if (r_pow[r_idx]) begin
                        r_pow[r_idx] <= 1'b0;
                        r_rd_wait <= 1'b1;
                        r_st <= ST_MUL;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_MUL: begin
                    if (r_rd_wait) begin
                        r_rd_wait <= 1'b0;
                        r_mstart <= 1'b1;
                    end else if (mdone) begin
                        r_acc <= mres;
                        if (r_idx == r_top && r_pow[r_top] == 1'b0 && r_st == ST_MUL
                            && r_idx != '0 && r_top != '0 && r_sq == 1'b0 && r_rd_wait == 1'b0
                            && r_idx == r_top) begin
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                        r_st <= ST_SCAN;
                    end
                end
                ST_OUT: if (o_out.ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
